// ===== rtl/tic_pkg.sv =====
// Shared widths and word types for the tetrahedron incenter pipeline.
package tic_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned Chunk   = 34;
  localparam int unsigned MulLat  = 2;
  localparam int unsigned EdgeW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * EdgeW;
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned SqW     = 2 * CrossW;
  localparam int unsigned NormW   = SqW + 2;
  localparam int unsigned RootW   = NormW / 2;
  localparam int unsigned SumW    = RootW + 2;
  localparam int unsigned WProdW  = RootW + 1 + CoordW;
  localparam int unsigned NumW    = WProdW + 2;
  localparam int unsigned DivNW   = NumW + 1;
  localparam int unsigned DivDW   = SumW + 1;
  localparam int unsigned QW      = CoordW + 1;
  localparam int unsigned FaceLat = 1 + MulLat + 1 + MulLat + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } in_word_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    logic   degenerate;
  } out_word_t;

endpackage

// ===== rtl/tetrahedron_incenter.sv =====
// Top level of the tetrahedron incenter pipeline.
// The input word carries the four corners of one tetrahedron as signed
// Q16.16 coordinates; the output word carries the incenter, saturated to
// the coordinate range, and a flag for a tetrahedron of zero total area.
// Both channels use valid and ready. A new word is taken in every cycle in
// which the pipeline is not stalled, so throughput is one word per cycle.
// Most of the pipeline depth comes from the pipelined square root, one bit
// per stage over 68 stages, and the pipelined divider, one quotient bit per
// stage over 33 stages.
// The whole pipeline advances together. When the output word is valid and
// the receiver holds ready low, every stage holds and in_ready_o drops in
// the same cycle, so no word is lost or repeated.
// Reset clears all valid bits; data registers hold stale values until
// they are overwritten and are never presented as valid.
module tetrahedron_incenter import tic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CoordDly = FaceLat + RootW + 1;
  localparam int unsigned TailLat  = MulLat + 2 + QW + 1;
  localparam int unsigned VldLen   = CoordDly + TailLat + 1;

  logic                       en;
  logic [VldLen-1:0]          vld_q;
  vec3_t                      p_d [4];
  vec3_t                      p_q [4];
  vec3_t                      dly_q [CoordDly][4];
  logic [NormW-1:0]           n2 [4];
  logic [RootW-1:0]           root [4];
  logic [RootW-1:0]           area_q [4];
  logic [SumW-1:0]            sum_q;
  logic [SumW-1:0]            sum_p_q [3];
  logic signed [WProdW-1:0]   wp [4][3];
  logic signed [NumW-1:0]     num_q [3];
  logic [DivNW-1:0]           nd_q [3];
  logic [DivDW-1:0]           dd_q;
  logic [2:0]                 neg_q;
  logic                       degen_q;
  logic [2:0]                 neg_dly_q [QW];
  logic                       degen_dly_q [QW];
  logic [QW-1:0]              quo [3];
  out_word_t                  out_d;
  out_word_t                  out_q;

  assign en         = ~vld_q[VldLen-1] | out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    p_d[0] = {in_word_i.p0_z, in_word_i.p0_y, in_word_i.p0_x};
    p_d[1] = {in_word_i.p1_z, in_word_i.p1_y, in_word_i.p1_x};
    p_d[2] = {in_word_i.p2_z, in_word_i.p2_y, in_word_i.p2_x};
    p_d[3] = {in_word_i.p3_z, in_word_i.p3_y, in_word_i.p3_x};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[VldLen-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
      dly_q[0] <= p_q;
      for (int i = 1; i < CoordDly; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  tic_face u_face0 (.clk_i(clk_i), .en_i(en), .o_i(p_q[3]), .a_i(p_q[1]),
                    .b_i(p_q[2]), .n2_o(n2[0]));
  tic_face u_face1 (.clk_i(clk_i), .en_i(en), .o_i(p_q[0]), .a_i(p_q[2]),
                    .b_i(p_q[3]), .n2_o(n2[1]));
  tic_face u_face2 (.clk_i(clk_i), .en_i(en), .o_i(p_q[0]), .a_i(p_q[1]),
                    .b_i(p_q[3]), .n2_o(n2[2]));
  tic_face u_face3 (.clk_i(clk_i), .en_i(en), .o_i(p_q[0]), .a_i(p_q[1]),
                    .b_i(p_q[2]), .n2_o(n2[3]));

  for (genvar i = 0; i < 4; i++) begin : g_area
    tic_isqrt #(.NW(NormW)) u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .n_i    (n2[i]),
      .root_o (root[i])
    );

    for (genvar k = 0; k < 3; k++) begin : g_wgt
      tic_mul #(.AW(RootW + 1), .BW(CoordW)) u_wmul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   ({1'b0, area_q[i]}),
        .b_i   (dly_q[CoordDly-1][i][k]),
        .p_o   (wp[i][k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q <= root;
      sum_q  <= SumW'(root[0]) + SumW'(root[1]) + SumW'(root[2]) + SumW'(root[3]);
      sum_p_q[0] <= sum_q;
      sum_p_q[1] <= sum_p_q[0];
      sum_p_q[2] <= sum_p_q[1];
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= NumW'(wp[0][k]) + NumW'(wp[1][k]) + NumW'(wp[2][k])
                  + NumW'(wp[3][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= num_q[k][NumW-1];
        nd_q[k]  <= (DivNW'(num_q[k][NumW-1] ? NumW'(-num_q[k]) : NumW'(num_q[k])) << 1)
                  + DivNW'(sum_p_q[2]);
      end
      dd_q    <= {sum_p_q[2], 1'b0};
      degen_q <= sum_p_q[2] == '0;
      neg_dly_q[0]   <= neg_q;
      degen_dly_q[0] <= degen_q;
      for (int i = 1; i < QW; i++) begin
        neg_dly_q[i]   <= neg_dly_q[i-1];
        degen_dly_q[i] <= degen_dly_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    tic_div #(.NW(DivNW), .DW(DivDW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (nd_q[k]),
      .d_i   (dd_q),
      .q_o   (quo[k])
    );
  end

  function automatic coord_t sat_coord(input logic neg, input logic [QW-1:0] mag);
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    lim = QW'(1) << (CoordW - 1);
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      return CoordW'(-m);
    end else begin
      m = (mag > lim - QW'(1)) ? lim - QW'(1) : mag;
      return CoordW'(m);
    end
  endfunction

  always_comb begin
    if (degen_dly_q[QW-1]) begin
      out_d.center_x   = '0;
      out_d.center_y   = '0;
      out_d.center_z   = '0;
      out_d.degenerate = 1'b1;
    end else begin
      out_d.center_x   = sat_coord(neg_dly_q[QW-1][0], quo[0]);
      out_d.center_y   = sat_coord(neg_dly_q[QW-1][1], quo[1]);
      out_d.center_z   = sat_coord(neg_dly_q[QW-1][2], quo[2]);
      out_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[VldLen-1];
  assign out_word_o  = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.degenerate |->
      out_word_o.center_x == '0 && out_word_o.center_y == '0 &&
      out_word_o.center_z == '0)
    else $error("degenerate word carries a nonzero center");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output word");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

// ===== rtl/tic_mul.sv =====
// Two-stage signed multiplier built from registered partial products.
module tic_mul import tic_pkg::*; #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned NA = (AW + Chunk - 1) / Chunk;
  localparam int unsigned NB = (BW + Chunk - 1) / Chunk;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned XW = (NA + NB) * Chunk;

  logic [AW-1:0]          ma;
  logic [BW-1:0]          mb;
  logic [NA*Chunk-1:0]    ax;
  logic [NB*Chunk-1:0]    bx;
  logic [2*Chunk-1:0]     pp_q [NA][NB];
  logic                   neg_q;
  logic [XW-1:0]          acc;
  logic signed [PW-1:0]   mag;
  logic signed [PW-1:0]   p_d;
  logic signed [PW-1:0]   p_q;

  assign ma = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign mb = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
  assign ax = (NA*Chunk)'(ma);
  assign bx = (NB*Chunk)'(mb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ax[i*Chunk +: Chunk] * bx[j*Chunk +: Chunk];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (XW'(pp_q[i][j]) << ((i + j) * Chunk));
      end
    end
    mag = PW'(acc);
    p_d = neg_q ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/tic_face.sv =====
// Squared norm of the cross product of the edge vectors a_i - o_i and b_i - o_i of one face.
module tic_face import tic_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  vec3_t            o_i,
  input  vec3_t            a_i,
  input  vec3_t            b_i,
  output logic [NormW-1:0] n2_o
);

  logic signed [EdgeW-1:0]  e1_q [3];
  logic signed [EdgeW-1:0]  e2_q [3];
  logic signed [ProdW-1:0]  t1 [3];
  logic signed [ProdW-1:0]  t2 [3];
  logic signed [CrossW-1:0] c_q [3];
  logic signed [SqW-1:0]    sq [3];
  logic [NormW-1:0]         n2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= EdgeW'($signed(a_i[k])) - EdgeW'($signed(o_i[k]));
        e2_q[k] <= EdgeW'($signed(b_i[k])) - EdgeW'($signed(o_i[k]));
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int unsigned U = (k + 1) % 3;
    localparam int unsigned V = (k + 2) % 3;

    tic_mul #(.AW(EdgeW), .BW(EdgeW)) u_t1 (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (e1_q[U]),
      .b_i   (e2_q[V]),
      .p_o   (t1[k])
    );

    tic_mul #(.AW(EdgeW), .BW(EdgeW)) u_t2 (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (e1_q[V]),
      .b_i   (e2_q[U]),
      .p_o   (t2[k])
    );

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k] <= CrossW'(t1[k]) - CrossW'(t2[k]);
      end
    end

    tic_mul #(.AW(CrossW), .BW(CrossW)) u_sq (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (c_q[k]),
      .b_i   (c_q[k]),
      .p_o   (sq[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q <= NormW'($unsigned(sq[0])) + NormW'($unsigned(sq[1]))
            + NormW'($unsigned(sq[2]));
    end
  end

  assign n2_o = n2_q;

endmodule

// ===== rtl/tic_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
module tic_isqrt import tic_pkg::*; #(
  parameter int unsigned NW = 136
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NW-1:0]     n_i,
  output logic [NW/2-1:0]   root_o
);

  localparam int unsigned RW   = NW / 2;
  localparam int unsigned RemW = RW + 2;

  logic [RemW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [NW-1:0]   rad_q  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RemW-1:0]   rem_in;
    logic [RW-1:0]     root_in;
    logic [NW-1:0]     rad_in;
    logic [RemW+1:0]   rem_sh;
    logic [RemW+1:0]   trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = n_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign rem_sh = {rem_in, rad_in[NW-1:NW-2]};
    assign trial  = (RemW+2)'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
        root_q[s] <= {root_in[RW-2:0], ge};
        rad_q[s]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== rtl/tic_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tic_div import tic_pkg::*; #(
  parameter int unsigned NW = 104,
  parameter int unsigned DW = 71,
  parameter int unsigned QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] d_q   [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   r2;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = DW'(n_i >> QW);
      assign d_in   = d_i;
      assign lo_in  = n_i[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign d_in   = d_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign r2 = {rem_in, lo_in[QW-1]};
    assign ge = r2 >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DW'(r2 - {1'b0, d_in}) : DW'(r2);
        d_q[s]   <= d_in;
        lo_q[s]  <= lo_in << 1;
        quo_q[s] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign q_o = quo_q[QW-1];

endmodule

// ===== dv/tb_tetrahedron_incenter.sv =====
// Self-checking testbench for the tetrahedron incenter pipeline with a built-in predictor.
module tb_tetrahedron_incenter;
  import tic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 500;
  localparam int CycleLimit = 400000;
  localparam int Latency    = 114;

  typedef logic signed [255:0] wide_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  out_word_t centers_due[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        sending_done = 1'b0;
  bit        held_for_drain = 1'b0;

  tetrahedron_incenter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic wide_t floor_sqrt(wide_t n);
    wide_t root, trial;
    root = '0;
    for (int b = 127; b >= 0; b--) begin
      trial = root | (wide_t'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic wide_t face_area(wide_t o[3], wide_t a[3], wide_t b[3]);
    wide_t e1[3], e2[3], c, n2;
    n2 = '0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = a[k] - o[k];
      e2[k] = b[k] - o[k];
    end
    for (int k = 0; k < 3; k++) begin
      c = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
      n2 += c * c;
    end
    return floor_sqrt(n2);
  endfunction

  function automatic out_word_t incenter_of(in_word_t w);
    wide_t p[4][3], area[4], total, num, q;
    logic [31:0] flat [12];
    out_word_t r;
    bit neg;
    flat = '{w.p0_x, w.p0_y, w.p0_z, w.p1_x, w.p1_y, w.p1_z,
             w.p2_x, w.p2_y, w.p2_z, w.p3_x, w.p3_y, w.p3_z};
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) p[i][k] = wide_t'(signed'(flat[i*3+k]));
    area[0] = face_area(p[3], p[1], p[2]);
    area[1] = face_area(p[0], p[2], p[3]);
    area[2] = face_area(p[0], p[1], p[3]);
    area[3] = face_area(p[0], p[1], p[2]);
    total = area[0] + area[1] + area[2] + area[3];
    r = '0;
    if (total == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      num = '0;
      for (int i = 0; i < 4; i++) num += area[i] * p[i][k];
      neg = num < 0;
      if (neg) num = -num;
      q = (2 * num + total) / (2 * total);
      if (neg) q = (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
      else if (q > 64'sd2147483647) q = 64'sd2147483647;
      case (k)
        0: r.center_x = q[31:0];
        1: r.center_y = q[31:0];
        default: r.center_z = q[31:0];
      endcase
    end
    return r;
  endfunction

  function automatic in_word_t random_tetra(int mode);
    in_word_t w;
    logic [31:0] base;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode == 1) begin
      // X coordinates near a random offset; y and z stay random.
      base = $urandom;
      w.p0_x = base + $urandom_range(0, 255); w.p1_x = base + $urandom_range(0, 255);
      w.p2_x = base + $urandom_range(0, 255); w.p3_x = base + $urandom_range(0, 255);
    end else if (mode == 2) begin
      // Coplanar corners, so every face area is zero only if also collinear.
      w.p0_z = 0; w.p1_z = 0; w.p2_z = 0; w.p3_z = 0;
    end else if (mode == 3) begin
      w.p1_x = w.p0_x; w.p1_y = w.p0_y; w.p1_z = w.p0_z;
      w.p2_x = w.p0_x; w.p2_y = w.p0_y; w.p2_z = w.p0_z;
    end
    return w;
  endfunction

  typedef struct {
    in_word_t  word;
    bit        known;
    out_word_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];
  localparam coord_t Max = 32'sh7fffffff;
  localparam coord_t Min = 32'sh80000000;
  localparam coord_t One = 32'sh00010000;

  task automatic send_word(in_word_t w, bit known, out_word_t r);
    int idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    centers_due.push_back(known ? r : incenter_of(w));
    @(negedge clk_i);
  endtask

  initial begin
    out_word_t zero_deg;
    zero_deg = '0;
    zero_deg.degenerate = 1'b1;
    directed_rows.push_back('{'0, 1'b1, zero_deg});
    directed_rows.push_back('{{12{Max}}, 1'b1, zero_deg});
    directed_rows.push_back('{{12{Min}}, 1'b1, zero_deg});
    directed_rows.push_back('{{Max, Max, Max, Max, Max, Max, Max, Max, Max, Max, Max, Max},
                              1'b1, zero_deg});
    directed_rows.push_back('{{32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0,
                               32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One}, 1'b0, '0});
    directed_rows.push_back('{{Min, Min, Min, Max, Min, Min,
                               Min, Max, Min, Min, Min, Max}, 1'b0, '0});
    directed_rows.push_back('{{Max, Max, Max, Min, Max, Max,
                               Max, Min, Max, Max, Max, Min}, 1'b0, '0});
    directed_rows.push_back('{{Min, Max, Min, Max, Min, Max,
                               Max, Max, Min, Min, Min, Max}, 1'b0, '0});
    directed_rows.push_back('{{32'sd0, 32'sd0, 32'sd0, One, One, One,
                               2*One, 2*One, 2*One, 3*One, 3*One, 3*One}, 1'b1, zero_deg});
    directed_rows.push_back('{{32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0,
                               32'sd0, One, 32'sd0, One, One, 32'sd0}, 1'b0, '0});
    directed_rows.push_back('{{-One, -One, -One, 32'sd1, 32'sd0, 32'sd0,
                               32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b0, '0});
    directed_rows.push_back('{{32'hffffffff, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h0,
                               32'h0, 32'h0, 32'hffffffff, 32'h55555555, 32'haaaaaaaa,
                               32'h12345678}, 1'b0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        while (centers_due.size() != 0) @(negedge clk_i);
        held_for_drain = 1'b1;
      end
      send_word(random_tetra($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3)), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int wait_n;
    @(negedge clk_i);
    forever begin
      wait_n = $urandom_range(0, 3);
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (centers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: %p", out_word_o);
      end else begin
        out_word_t want;
        want = centers_due.pop_front();
        if (out_word_o.center_x !== want.center_x || out_word_o.center_y !== want.center_y ||
            out_word_o.center_z !== want.center_z ||
            out_word_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_word_o);
        end
      end
    end
  end

  initial begin
    while (!(sending_done && centers_due.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (Latency + 10) @(posedge clk_i);
      if (mismatches == 0 && held_for_drain) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
    end
  end
endmodule

// ===== sim.f =====
rtl/tic_pkg.sv
rtl/tic_mul.sv
rtl/tic_face.sv
rtl/tic_isqrt.sv
rtl/tic_div.sv
rtl/tetrahedron_incenter.sv
dv/tb_tetrahedron_incenter.sv
